>>> rtl/core/mcspr_pkg.sv
// Shared types and constants for the multi-channel servo pulse ramp core.
package mcspr_pkg;

    localparam int JOINTS_DEFAULT = 5;

    localparam int PW_W       = 14;
    localparam int STEP_W     = 16;
    localparam int ANGLE_W    = 11;
    localparam int DUR_W      = 15;
    localparam int JOINT_W    = 3;
    localparam int DIVIDEND_W = 18;
    localparam int COUNT_W    = 5;

    localparam logic [PW_W-1:0]  NEUTRAL_COUNTS  = 14'd9000;
    localparam logic [PW_W-1:0]  MIN_COUNTS      = 14'd3000;
    localparam logic [PW_W-1:0]  COUNTS_PER_DDEG = 14'd6;
    localparam logic [DUR_W-1:0] MIN_DURATION    = 15'd10;

    localparam logic FUNC_COMMAND = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    typedef struct packed {
        logic               func;
        logic [JOINT_W-1:0] joint;
        logic [ANGLE_W-1:0] angle;
        logic [DUR_W-1:0]   duration_ms;
        logic               fault;
    } item_t;

    typedef struct packed {
        logic [JOINT_W-1:0] out_joint;
        logic [PW_W-1:0]    pulse_width;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [PW_W-1:0]          position;
        logic [PW_W-1:0]          goal;
        logic signed [STEP_W-1:0] step_size;
    } jf_rd_t;

    typedef struct packed {
        logic                     pos_we;
        logic                     goal_we;
        logic                     step_we;
        logic [PW_W-1:0]          position;
        logic [PW_W-1:0]          goal;
        logic signed [STEP_W-1:0] step_size;
    } jf_wr_t;

endpackage

>>> rtl/core/mcspr_divider.sv
// Restoring divider producing one quotient bit per cycle.
module mcspr_divider
    import mcspr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DUR_W-1:0]      divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [DUR_W-1:0]   rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quot_reg, quot_next;
    logic [DUR_W-1:0]   dsr_reg, dsr_next;
    logic [DUR_W:0]     shifted;
    logic [DUR_W:0]     trial;

    assign shifted = {rem_reg, quot_reg[DIVIDEND_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        run_next   = run_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        dsr_next   = dsr_reg;
        if (start)
        begin
            run_next   = 1'b1;
            count_next = COUNT_W'(DIVIDEND_W - 1);
            rem_next   = '0;
            quot_next  = dividend;
            dsr_next   = divisor;
        end
        else if (run_reg)
        begin
            if (!trial[DUR_W])
            begin
                rem_next  = trial[DUR_W-1:0];
                quot_next = {quot_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[DUR_W-1:0];
                quot_next = {quot_reg[DIVIDEND_W-2:0], 1'b0};
            end
            count_next = count_reg - COUNT_W'(1);
            if (count_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            run_reg   <= run_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dsr_reg  <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

>>> rtl/core/mcspr_joint_file.sv
// Per-joint position, goal and step registers with one shared access port.
module mcspr_joint_file
    import mcspr_pkg::*;
#(
    parameter int JOINTS = JOINTS_DEFAULT,
    parameter int JW     = (JOINTS > 1) ? $clog2(JOINTS) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [JW-1:0] idx,
    input  jf_wr_t        wr,
    output jf_rd_t        rd
);

    logic [PW_W-1:0]          position_reg [JOINTS];
    logic [PW_W-1:0]          goal_reg     [JOINTS];
    logic signed [STEP_W-1:0] step_reg     [JOINTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < JOINTS; j++)
            begin
                position_reg[j] <= NEUTRAL_COUNTS;
                goal_reg[j]     <= NEUTRAL_COUNTS;
                step_reg[j]     <= '0;
            end
        end
        else
        begin
            for (int j = 0; j < JOINTS; j++)
            begin
                if (idx == JW'(j))
                begin
                    if (wr.pos_we)
                    begin
                        position_reg[j] <= wr.position;
                    end
                    if (wr.goal_we)
                    begin
                        goal_reg[j] <= wr.goal;
                    end
                    if (wr.step_we)
                    begin
                        step_reg[j] <= wr.step_size;
                    end
                end
            end
        end
    end

    always_comb
    begin
        rd = '0;
        for (int j = 0; j < JOINTS; j++)
        begin
            if (idx == JW'(j))
            begin
                rd.position  = position_reg[j];
                rd.goal      = goal_reg[j];
                rd.step_size = step_reg[j];
            end
        end
    end

endmodule

>>> rtl/core/multi_channel_servo_pulse_ramp_core.sv
// Top level of the servo pulse ramp core: sequencer, tick walk and result register.
// A command holds busy: fetch joint, write goal, 18 divider steps if it moves, write step.
// A tick keeps busy high as it walks all joints, one per cycle through the single register port.
// Results of a tick appear on consecutive cycles in joint order, each from the result register.
// The receiver cannot stall; each result strobe lasts exactly one cycle.
// After reset every position and goal is 9000 counts and every step is zero.
module multi_channel_servo_pulse_ramp_core
    import mcspr_pkg::*;
#(
    parameter int JOINTS = JOINTS_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    result_strobe,
    output result_t result
);

    localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_TICK
    } state_t;

    state_t           state_reg, state_next;
    logic [JW-1:0]    idx_reg, idx_next;
    logic             strobe_reg, strobe_next;
    result_t          result_reg, result_next;
    logic [PW_W-1:0]  goal_reg, goal_next;
    logic [DUR_W-1:0] dur_reg, dur_next;
    logic             fault_reg, fault_next;
    logic             neg_reg, neg_next;

    jf_rd_t                  rd;
    jf_wr_t                  wr;
    logic                    div_start;
    logic [DIVIDEND_W-1:0]   dividend;
    logic                    div_done;
    logic [DIVIDEND_W-1:0]   quotient;
    logic [PW_W-1:0]         mag;
    logic signed [PW_W+3:0]  np;
    logic signed [PW_W+3:0]  g_ext;
    logic                    snap;
    logic                    accept;

    assign accept = start && (state_reg == ST_IDLE);

    assign mag      = (goal_reg < rd.position) ? (rd.position - goal_reg)
                                               : (goal_reg - rd.position);
    assign dividend = DIVIDEND_W'({mag, 3'b000}) + DIVIDEND_W'({mag, 1'b0});

    assign np    = $signed({4'b0000, rd.position})
                 + $signed({{2{rd.step_size[STEP_W-1]}}, rd.step_size});
    assign g_ext = $signed({4'b0000, rd.goal});
    assign snap  = ((rd.step_size < 0) && (np <= g_ext))
                || ((rd.step_size > 0) && (np >= g_ext));

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        goal_next   = goal_reg;
        dur_next    = dur_reg;
        fault_next  = fault_reg;
        neg_next    = neg_reg;
        wr          = '0;
        div_start   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    goal_next  = PW_W'({3'b000, item.angle} * COUNTS_PER_DDEG) + MIN_COUNTS;
                    dur_next   = (item.duration_ms < MIN_DURATION) ? MIN_DURATION
                                                                   : item.duration_ms;
                    fault_next = item.fault;
                    if (item.func == FUNC_TICK)
                    begin
                        idx_next   = '0;
                        state_next = ST_TICK;
                    end
                    else if (32'(item.joint) < 32'(JOINTS))
                    begin
                        idx_next   = JW'(item.joint);
                        state_next = ST_CALC;
                    end
                end
            end
            ST_CALC:
            begin
                wr.goal_we = 1'b1;
                wr.goal    = goal_reg;
                if (rd.position != goal_reg)
                begin
                    div_start  = 1'b1;
                    neg_next   = goal_reg < rd.position;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    wr.step_we   = 1'b1;
                    wr.step_size = neg_reg ? -$signed(STEP_W'(quotient))
                                           : $signed(STEP_W'(quotient));
                    state_next   = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                wr.position = rd.position;
                if (fault_reg)
                begin
                    wr.goal_we   = 1'b1;
                    wr.goal      = rd.position;
                    wr.step_we   = 1'b1;
                    wr.step_size = '0;
                end
                else if (rd.position != rd.goal)
                begin
                    wr.pos_we = 1'b1;
                    if (snap)
                    begin
                        wr.position  = rd.goal;
                        wr.step_we   = 1'b1;
                        wr.step_size = '0;
                    end
                    else
                    begin
                        wr.position = np[PW_W-1:0];
                    end
                end
                strobe_next             = 1'b1;
                result_next.out_joint   = JOINT_W'(idx_reg);
                result_next.pulse_width = wr.position;
                result_next.last        = idx_reg == JW'(JOINTS - 1);
                if (idx_reg == JW'(JOINTS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + JW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        goal_reg  <= goal_next;
        dur_reg   <= dur_next;
        fault_reg <= fault_next;
        neg_reg   <= neg_next;
    end

    mcspr_joint_file #(
        .JOINTS (JOINTS),
        .JW     (JW)
    ) u_joint_file (
        .clk   (clk),
        .rst_n (rst_n),
        .idx   (idx_reg),
        .wr    (wr),
        .rd    (rd)
    );

    mcspr_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (dur_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign busy          = state_reg != ST_IDLE;
    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    // Only the tick walk produces results.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(state_reg == ST_TICK))
        else $error("result strobe without a tick step");

    // The final report of a tick is never followed directly by another report.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.last |=> !result_strobe)
        else $error("report follows the final report of a tick");

    // A report that is not the final one comes while the tick walk is still running.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.last |-> busy)
        else $error("tick walk ended before its final report");

    // The divider finishes only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the division wait");

endmodule
